### sv/eida_pkg.sv
// ============================================================================
// eida_pkg
// Types, constants and controller/datapath command and status groups for
// the entity ID allocator.
// ============================================================================
package eida_pkg;

    localparam int ID_BITS      = 16;
    localparam int ACTIVE_DEPTH = 64;
    localparam int REUSE_DEPTH  = 64;

    localparam int ACT_AW  = $clog2(ACTIVE_DEPTH);
    localparam int ACT_CW  = $clog2(ACTIVE_DEPTH + 1);
    localparam int RS_AW   = $clog2(REUSE_DEPTH);
    localparam int RS_CW   = $clog2(REUSE_DEPTH + 1);

    localparam int ACTION_W = 2;
    localparam int EID_W    = 16;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = ((ACTION_W + EID_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((EID_W + STATUS_W + 1 + 7) / 8) * 8;

    typedef logic [ID_BITS-1:0] id_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CREATE  = 2'd0,
        ACT_CLAIM   = 2'd1,
        ACT_DESTROY = 2'd2,
        ACT_NOP     = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MODE_CLAIM,
        MODE_DESTROY,
        MODE_POP,
        MODE_SCAN
    } mode_t;

    typedef enum logic [1:0] {
        CAND_HOLD,
        CAND_POP,
        CAND_FIRST,
        CAND_NEXT
    } cand_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_CREATE,
        S_POP_RD,
        S_POP_LD,
        S_SRCH,
        S_CMP,
        S_DEL_RD,
        S_DEL_MV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic      load_in;
        cand_sel_t cand_sel;
        logic      idx_clr;
        logic      act_rd;
        logic      rd_last;
        logic      rs_pop;
        logic      add;
        logic      remove;
        logic      set_last;
        logic      res_load;
        status_t   res_code;
        logic      res_use_id;
        logic      res_sched;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    key_zero;
        logic    idx_end;
        logic    match;
        logic    full;
        logic    rs_empty;
        logic    next_is_last;
    } sts_t;

endpackage

### sv/eida_ctrl.sv
// ============================================================================
// eida_ctrl
// Sequencer for the allocator: dispatches a request, runs the active-set
// search, the reuse-stack pops and the ID scan, and hands off the result.
// ============================================================================
module eida_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  eida_pkg::sts_t  sts,
    output eida_pkg::cmd_t  cmd
);

    eida_pkg::state_t state_reg, state_next;
    eida_pkg::mode_t  mode_reg, mode_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             hit, miss;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= eida_pkg::S_IDLE;
            mode_reg     <= eida_pkg::MODE_CLAIM;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        mode_next     = mode_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        hit           = 1'b0;
        miss          = 1'b0;

        unique case (state_reg)
            eida_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = eida_pkg::S_DISP;
                end
            end
            eida_pkg::S_DISP: begin
                unique case (sts.action)
                    eida_pkg::ACT_CREATE: begin
                        if (sts.full) begin
                            cmd.res_load = 1'b1;
                            cmd.res_code = eida_pkg::ST_FULL;
                            state_next   = eida_pkg::S_OUT;
                        end else begin
                            state_next = eida_pkg::S_CREATE;
                        end
                    end
                    eida_pkg::ACT_CLAIM: begin
                        if (sts.full) begin
                            cmd.res_load = 1'b1;
                            cmd.res_code = eida_pkg::ST_FULL;
                            state_next   = eida_pkg::S_OUT;
                        end else begin
                            mode_next  = eida_pkg::MODE_CLAIM;
                            state_next = eida_pkg::S_SRCH;
                        end
                    end
                    eida_pkg::ACT_DESTROY: begin
                        mode_next  = eida_pkg::MODE_DESTROY;
                        state_next = eida_pkg::S_SRCH;
                    end
                    default: begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = eida_pkg::ST_OK;
                        state_next   = eida_pkg::S_OUT;
                    end
                endcase
            end
            eida_pkg::S_CREATE: begin
                if (sts.rs_empty) begin
                    cmd.cand_sel = eida_pkg::CAND_FIRST;
                    cmd.idx_clr  = 1'b1;
                    mode_next    = eida_pkg::MODE_SCAN;
                    state_next   = eida_pkg::S_SRCH;
                end else begin
                    state_next = eida_pkg::S_POP_RD;
                end
            end
            eida_pkg::S_POP_RD: begin
                cmd.rs_pop = 1'b1;
                state_next = eida_pkg::S_POP_LD;
            end
            eida_pkg::S_POP_LD: begin
                cmd.cand_sel = eida_pkg::CAND_POP;
                cmd.idx_clr  = 1'b1;
                mode_next    = eida_pkg::MODE_POP;
                state_next   = eida_pkg::S_SRCH;
            end
            eida_pkg::S_SRCH: begin
                // ID 0 is never free and never active
                if (sts.key_zero) begin
                    if (mode_reg == eida_pkg::MODE_DESTROY) begin
                        miss = 1'b1;
                    end else begin
                        hit = 1'b1;
                    end
                end else if (sts.idx_end) begin
                    miss = 1'b1;
                end else begin
                    cmd.act_rd = 1'b1;
                    state_next = eida_pkg::S_CMP;
                end
            end
            eida_pkg::S_CMP: begin
                if (sts.match) begin
                    hit = 1'b1;
                end else begin
                    state_next = eida_pkg::S_SRCH;
                end
            end
            eida_pkg::S_DEL_RD: begin
                cmd.act_rd  = 1'b1;
                cmd.rd_last = 1'b1;
                state_next  = eida_pkg::S_DEL_MV;
            end
            eida_pkg::S_DEL_MV: begin
                cmd.remove     = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_code   = eida_pkg::ST_OK;
                cmd.res_use_id = 1'b1;
                cmd.res_sched  = 1'b1;
                state_next     = eida_pkg::S_OUT;
            end
            eida_pkg::S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = eida_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = eida_pkg::S_IDLE;
            end
        endcase

        // search outcome: hit means the candidate is taken
        if (hit) begin
            unique case (mode_reg)
                eida_pkg::MODE_CLAIM:   state_next = eida_pkg::S_CREATE;
                eida_pkg::MODE_DESTROY: state_next = eida_pkg::S_DEL_RD;
                eida_pkg::MODE_POP:     state_next = eida_pkg::S_CREATE;
                eida_pkg::MODE_SCAN: begin
                    if (sts.next_is_last) begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = eida_pkg::ST_NO_FREE;
                        state_next   = eida_pkg::S_OUT;
                    end else begin
                        cmd.cand_sel = eida_pkg::CAND_NEXT;
                        cmd.idx_clr  = 1'b1;
                        state_next   = eida_pkg::S_SRCH;
                    end
                end
                default: state_next = eida_pkg::S_IDLE;
            endcase
        end else if (miss) begin
            cmd.res_load = 1'b1;
            state_next   = eida_pkg::S_OUT;
            if (mode_reg == eida_pkg::MODE_DESTROY) begin
                cmd.res_code = eida_pkg::ST_NOT_FOUND;
            end else begin
                cmd.add        = 1'b1;
                cmd.set_last   = (mode_reg == eida_pkg::MODE_SCAN);
                cmd.res_code   = eida_pkg::ST_OK;
                cmd.res_use_id = 1'b1;
            end
        end
    end

    assign s_tready = (state_reg == eida_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

### sv/eida_dp.sv
// ============================================================================
// eida_dp
// Datapath: active table and reuse stack memories, their counts, the
// candidate and search index registers, and the result registers.
// ============================================================================
module eida_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [eida_pkg::S_DATA_W-1:0] s_tdata,
    output logic [eida_pkg::M_DATA_W-1:0] m_tdata,
    input  eida_pkg::cmd_t                cmd,
    output eida_pkg::sts_t                sts
);

    eida_pkg::id_t act_mem [eida_pkg::ACTIVE_DEPTH];
    eida_pkg::id_t rs_mem  [eida_pkg::REUSE_DEPTH];

    eida_pkg::action_t             action_reg;
    eida_pkg::id_t                 cand_reg, cand_next;
    eida_pkg::id_t                 last_reg;
    eida_pkg::id_t                 act_rd_reg, rs_rd_reg;
    logic [eida_pkg::ACT_CW-1:0]   idx_reg;
    logic [eida_pkg::ACT_CW-1:0]   act_cnt_reg;
    logic [eida_pkg::RS_CW-1:0]    rs_cnt_reg;
    eida_pkg::id_t                 res_id_reg;
    eida_pkg::status_t             res_code_reg;
    logic                          res_sched_reg;
    logic [eida_pkg::M_DATA_W-1:0] m_tdata_reg;

    eida_pkg::id_t                 req;
    eida_pkg::id_t                 cand_inc;
    logic [eida_pkg::ACT_CW-1:0]   act_top;
    logic [eida_pkg::ACT_CW-1:0]   slot_full;
    logic [eida_pkg::RS_CW-1:0]    rs_top;
    logic [eida_pkg::ACT_AW-1:0]   act_rd_addr;
    logic                          rs_room;
    logic                          push;

    assign req       = eida_pkg::ID_BITS'(s_tdata[eida_pkg::ACTION_W +: eida_pkg::EID_W]);
    assign cand_inc  = cand_reg + 1'b1;
    assign act_top   = act_cnt_reg - 1'b1;
    assign slot_full = idx_reg - 1'b1;
    assign rs_top    = rs_cnt_reg - 1'b1;
    assign rs_room   = (rs_cnt_reg < eida_pkg::RS_CW'(eida_pkg::REUSE_DEPTH));
    assign push      = cmd.remove && rs_room;
    assign act_rd_addr = cmd.rd_last ? act_top[eida_pkg::ACT_AW-1:0]
                                     : idx_reg[eida_pkg::ACT_AW-1:0];

    always_comb begin
        unique case (cmd.cand_sel)
            eida_pkg::CAND_POP:   cand_next = rs_rd_reg;
            eida_pkg::CAND_FIRST: cand_next = last_reg + 1'b1;
            eida_pkg::CAND_NEXT:  cand_next = cand_inc;
            default:              cand_next = cand_reg;
        endcase
        if (cmd.load_in) begin
            cand_next = req;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_cnt_reg <= '0;
            rs_cnt_reg  <= '0;
            last_reg    <= '0;
        end else begin
            if (cmd.add) begin
                act_cnt_reg <= act_cnt_reg + 1'b1;
            end else if (cmd.remove) begin
                act_cnt_reg <= act_top;
            end
            if (cmd.rs_pop) begin
                rs_cnt_reg <= rs_top;
            end else if (push) begin
                rs_cnt_reg <= rs_cnt_reg + 1'b1;
            end
            if (cmd.set_last) begin
                last_reg <= cand_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;
        if (cmd.load_in) begin
            action_reg <= eida_pkg::action_t'(s_tdata[eida_pkg::ACTION_W-1:0]);
        end
        if (cmd.load_in || cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.act_rd && !cmd.rd_last) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.res_load) begin
            res_id_reg    <= cmd.res_use_id ? cand_reg : '0;
            res_code_reg  <= cmd.res_code;
            res_sched_reg <= cmd.res_sched;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= eida_pkg::M_DATA_W'({res_sched_reg, res_code_reg,
                                                eida_pkg::EID_W'(res_id_reg)});
        end
    end

    // active table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.add) begin
            act_mem[act_cnt_reg[eida_pkg::ACT_AW-1:0]] <= cand_reg;
        end else if (cmd.remove) begin
            // move the last entry into the freed slot
            act_mem[slot_full[eida_pkg::ACT_AW-1:0]] <= act_rd_reg;
        end
        if (cmd.act_rd) begin
            act_rd_reg <= act_mem[act_rd_addr];
        end
    end

    // reuse stack
    always_ff @(posedge aclk) begin
        if (push) begin
            rs_mem[rs_cnt_reg[eida_pkg::RS_AW-1:0]] <= cand_reg;
        end
        if (cmd.rs_pop) begin
            rs_rd_reg <= rs_mem[rs_top[eida_pkg::RS_AW-1:0]];
        end
    end

    assign sts.action       = action_reg;
    assign sts.key_zero     = (cand_reg == '0);
    assign sts.idx_end      = (idx_reg == act_cnt_reg);
    assign sts.match        = (act_rd_reg == cand_reg);
    assign sts.full         = (act_cnt_reg == eida_pkg::ACT_CW'(eida_pkg::ACTIVE_DEPTH));
    assign sts.rs_empty     = (rs_cnt_reg == '0);
    assign sts.next_is_last = (cand_inc == last_reg);

    assign m_tdata = m_tdata_reg;

endmodule

### sv/entity_id_allocator_core.sv
// ============================================================================
// entity_id_allocator_core
// Entity ID allocator with an active table, a reuse stack and a wrap scan.
// ============================================================================
// One request word in on the s_ channel, one result word out on the m_
// channel. A request is create, claim (take the given ID, else create) or
// destroy. Freed IDs go on a reuse stack and are handed out first; when it
// is empty the allocator scans upward from the last scanned ID.
// The block works on one request at a time. Each active-set lookup walks
// the active table through its single read port, one entry after another,
// reading each entry and then comparing it. Claim and destroy run one
// lookup each; create runs one lookup per reuse-stack entry popped or
// per ID the scan steps over. The result sits in an output register: the
// next request is taken while it waits, and a stalled receiver only holds
// the block once the following result is ready.
// Reset empties the active table, the reuse stack and the output register
// and sets the last scanned ID to 0, with no clearing pass.
// ============================================================================
module entity_id_allocator_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] action, [17:2] entity_id
    input  logic [eida_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] result_id, [17:16] status, [18] schedule_deletion
    output logic [eida_pkg::M_DATA_W-1:0] m_tdata
);

    eida_pkg::cmd_t cmd;
    eida_pkg::sts_t sts;

    eida_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    eida_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .sts     (sts)
    );

    // one request in flight: no word accepted right after another
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while one is in flight");

    // a deletion request goes only with a successful destroy
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18] |->
            m_tdata[17:16] == eida_pkg::ST_OK && m_tdata[15:0] != '0)
        else $error("deletion flagged without a destroyed ID");

    // failures never carry an ID
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17:16] != eida_pkg::ST_OK |-> m_tdata[15:0] == '0)
        else $error("failed request returned an ID");

    // never add to a full table
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.add |-> !sts.full)
        else $error("add to full active table");

endmodule

### tb/entity_id_alloc_checker.sv
// ============================================================================
// entity_id_alloc_checker
// Predicts and checks every result word of the entity ID allocator.
// ============================================================================
// Watches both channels of the allocator. Each request word accepted on the
// s_ side is run through a local copy of the active table, reuse stack and
// scan position. The predicted answer is queued, and each result word taken
// on the m_ side is compared field by field against the oldest prediction.
// Mismatches and unexpected words are counted in fail_count. pending holds
// the number of predictions still waiting for their result.
// ============================================================================
module entity_id_alloc_checker
    import eida_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    // [1:0] action, [17:2] entity_id
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    // [15:0] result_id, [17:16] status, [18] schedule_deletion
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic    sched;
        status_t status;
        id_t     id;
    } alloc_word_t;

    id_t         live_tbl [ACTIVE_DEPTH];
    int          live_n;
    id_t         free_stk [REUSE_DEPTH];
    int          free_n;
    id_t         last_scan;
    alloc_word_t want_words [$];

    initial begin
        fail_count = 0;
        pending    = 0;
        live_n     = 0;
        free_n     = 0;
        last_scan  = '0;
    end

    task automatic report_mismatch(string field, int got, int want);
        $display("%0t: %s mismatch, got %0d, want %0d", $time, field, got, want);
        fail_count++;
    endtask

    function automatic bit find_live(id_t id, output int slot);
        slot = 0;
        for (int i = 0; i < live_n; i++) begin
            if (live_tbl[i] == id) begin
                slot = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void mark_live(id_t id);
        if (live_n < ACTIVE_DEPTH) begin
            live_tbl[live_n] = id;
            live_n++;
        end
    endfunction

    // Reuse stack first, then the upward scan from the last scanned ID.
    function automatic status_t issue_id(output id_t got);
        id_t cand;
        int  slot;
        got = '0;
        if (live_n >= ACTIVE_DEPTH) return ST_FULL;
        while (free_n > 0) begin
            free_n--;
            cand = free_stk[free_n];
            // drop freed IDs that were claimed again meanwhile
            if (cand != '0 && !find_live(cand, slot)) begin
                mark_live(cand);
                got = cand;
                return ST_OK;
            end
        end
        cand = last_scan + 1'b1;
        while (cand != last_scan) begin
            if (cand != '0 && !find_live(cand, slot)) begin
                last_scan = cand;
                mark_live(cand);
                got = cand;
                return ST_OK;
            end
            cand = cand + 1'b1;
        end
        return ST_NO_FREE;
    endfunction

    function automatic alloc_word_t predict_request(action_t act, id_t req);
        alloc_word_t w;
        id_t         got;
        int          slot;
        w = '0;
        case (act)
            ACT_CREATE: begin
                w.status = issue_id(got);
                w.id     = got;
            end
            ACT_CLAIM: begin
                if (req != '0 && !find_live(req, slot)) begin
                    if (live_n >= ACTIVE_DEPTH) begin
                        w.status = ST_FULL;
                    end else begin
                        mark_live(req);
                        w.id = req;
                    end
                end else begin
                    w.status = issue_id(got);
                    w.id     = got;
                end
            end
            ACT_DESTROY: begin
                if (req != '0 && find_live(req, slot)) begin
                    // move the last entry into the freed slot
                    live_n--;
                    live_tbl[slot] = live_tbl[live_n];
                    if (free_n < REUSE_DEPTH) begin
                        free_stk[free_n] = req;
                        free_n++;
                    end
                    w.id    = req;
                    w.sched = 1'b1;
                end else begin
                    w.status = ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
        return w;
    endfunction

    always @(posedge aclk) begin : watch
        alloc_word_t got_w;
        alloc_word_t want_w;
        if (!aresetn) begin
            live_n    = 0;
            free_n    = 0;
            last_scan = '0;
            want_words.delete();
        end else begin
            // results first: a word leaving now belongs to an older request
            if (m_tvalid && m_tready) begin
                got_w = alloc_word_t'(m_tdata[$bits(alloc_word_t)-1:0]);
                if (want_words.size() == 0) begin
                    report_mismatch("unrequested word result_id", got_w.id, 0);
                end else begin
                    want_w = want_words.pop_front();
                    if (got_w.id != want_w.id)
                        report_mismatch("result_id", got_w.id, want_w.id);
                    if (got_w.status != want_w.status)
                        report_mismatch("status", int'(got_w.status), int'(want_w.status));
                    if (got_w.sched != want_w.sched)
                        report_mismatch("schedule_deletion", got_w.sched, want_w.sched);
                end
            end
            if (s_tvalid && s_tready)
                want_words.push_back(predict_request(action_t'(s_tdata[ACTION_W-1:0]),
                                                     s_tdata[ACTION_W +: ID_BITS]));
        end
        pending = want_words.size();
    end

endmodule

### tb/tb_entity_id_allocator_core.sv
// ============================================================================
// tb_entity_id_allocator_core
// Stimulus and verdict for the entity ID allocator.
// ============================================================================
// Drives create, claim, destroy and no-op requests: a directed opening that
// walks the scan, reuse and not-found paths, one full fill-and-drain of the
// table, then random phases that lean toward filling, draining or churning.
// Claim and destroy targets mostly come from IDs seen in earlier results,
// so many requests hit live or freed state. Both channels idle at random.
// Checking is done by entity_id_alloc_checker; a watchdog ends a stuck run.
// ============================================================================
module tb_entity_id_allocator_core;
    import eida_pkg::*;

    localparam int ITEMS      = 1200;
    localparam int IDLE_LIMIT = 100000;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    // [1:0] action, [17:2] entity_id
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    // [15:0] result_id, [17:16] status, [18] schedule_deletion
    logic [M_DATA_W-1:0] m_tdata;

    int      fail_count;
    int      pending;
    int      idle_cycles = 0;
    int      n_sent;
    bit      calm;
    id_t     scan_mark;
    id_t     live_ids  [$];
    id_t     freed_ids [$];
    action_t sent_acts [$];

    entity_id_allocator_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    entity_id_alloc_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic id_t pop_live();
        int  k;
        id_t v;
        k = $urandom_range(0, live_ids.size() - 1);
        v = live_ids[k];
        live_ids.delete(k);
        return v;
    endfunction

    function automatic id_t claim_target();
        int r;
        r = $urandom_range(0, 99);
        // just above the scan position, so later scans have to step over it
        if (r < 30) return scan_mark + id_t'($urandom_range(1, 8));
        if (r < 48 && freed_ids.size() > 0)
            return freed_ids[$urandom_range(0, freed_ids.size() - 1)];
        if (r < 62 && live_ids.size() > 0)
            return live_ids[$urandom_range(0, live_ids.size() - 1)];
        if (r < 92) return id_t'($urandom);
        if (r < 96) return '0;
        return '1;
    endfunction

    function automatic id_t destroy_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75 && live_ids.size() > 0) return pop_live();
        if (r < 85) return scan_mark - id_t'($urandom_range(0, 20));
        if (r < 92) return id_t'($urandom);
        if (r < 96) return '0;
        return '1;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_req(action_t act, id_t eid);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(S_DATA_W - ACTION_W - ID_BITS){1'b0}}, eid, act};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        // drop the word once taken so it is not offered again
        s_tvalid = 1'b0;
        if (act != ACT_NOP) n_sent++;
    endtask

    task automatic send_mixed(int create_w, int claim_w, int destroy_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < create_w)
            send_req(ACT_CREATE, id_t'($urandom));
        else if (r < create_w + claim_w)
            send_req(ACT_CLAIM, claim_target());
        else if (r < create_w + claim_w + destroy_w)
            send_req(ACT_DESTROY, destroy_target());
        else
            send_req(ACT_NOP, id_t'($urandom));
    endtask

    task automatic wait_quiet();
        while (pending != 0) @(negedge aclk);
    endtask

    // Empty the table, overfill it with claims, then free everything so the
    // reuse stack overflows.
    task automatic churn_table();
        id_t eid;
        wait_quiet();
        while (live_ids.size() > 0) send_req(ACT_DESTROY, pop_live());
        repeat (ACTIVE_DEPTH + 2) send_req(ACT_CLAIM, claim_target());
        wait_quiet();
        while (live_ids.size() > 0) send_req(ACT_DESTROY, pop_live());
        eid = id_t'($urandom_range(1, 65535));
        send_req(ACT_CLAIM, eid);
        send_req(ACT_DESTROY, eid);
    endtask

    // Track issued and freed IDs to aim later claims and destroys; watchdog.
    always @(posedge aclk) begin : steer
        action_t act;
        id_t     rid;
        status_t rst;
        logic    rsch;
        if (aresetn) begin
            if (m_tvalid && m_tready && sent_acts.size() > 0) begin
                act  = sent_acts.pop_front();
                rid  = m_tdata[ID_BITS-1:0];
                rst  = status_t'(m_tdata[ID_BITS +: STATUS_W]);
                rsch = m_tdata[ID_BITS + STATUS_W];
                if (rsch) begin
                    freed_ids.push_back(rid);
                    if (freed_ids.size() > 32) void'(freed_ids.pop_front());
                end else if (rst == ST_OK && rid != '0) begin
                    live_ids.push_back(rid);
                    if (act != ACT_DESTROY && rid > scan_mark && rid <= scan_mark + 64)
                        scan_mark = rid;
                end
            end
            if (s_tvalid && s_tready)
                sent_acts.push_back(action_t'(s_tdata[ACTION_W-1:0]));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : sink
        int g;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            m_tready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            g = pick_gap();
            if (g > 0) begin
                m_tready = 1'b0;
                repeat (g) @(negedge aclk);
            end
        end
    end

    initial begin : source
        int n;
        int kind;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        calm      = 1'b0;
        scan_mark = '0;
        n_sent    = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // scan from zero, claim ahead of the scan, fallbacks, not-found
        send_req(ACT_CREATE, '0);
        send_req(ACT_CREATE, '1);
        send_req(ACT_CLAIM, 16'd3);
        send_req(ACT_CREATE, '0);
        send_req(ACT_CLAIM, '0);
        send_req(ACT_CLAIM, 16'd4);
        send_req(ACT_DESTROY, '0);
        send_req(ACT_DESTROY, 16'd100);
        send_req(ACT_DESTROY, 16'd2);
        // claim a freed ID, leaving a stale reuse entry for the next create
        send_req(ACT_CLAIM, 16'd2);
        send_req(ACT_CREATE, '0);
        send_req(ACT_NOP, '1);
        send_req(ACT_NOP, '0);
        send_req(ACT_DESTROY, '1);
        send_req(ACT_CLAIM, '1);
        send_req(ACT_DESTROY, '1);
        send_req(ACT_CREATE, 16'h5A5A);
        send_req(ACT_DESTROY, 16'd1);
        send_req(ACT_DESTROY, 16'd3);
        send_req(ACT_CREATE, '0);
        send_req(ACT_CREATE, '0);

        // full table and full reuse stack early on
        churn_table();

        while (n_sent < ITEMS) begin
            n    = $urandom_range(40, 120);
            kind = $urandom_range(0, 9);
            calm = ($urandom_range(0, 3) == 0);
            case (kind)
                0, 1, 2, 3: repeat (n) send_mixed(40, 42, 15);
                4, 5, 6:    repeat (n) send_mixed(15, 15, 67);
                7:          churn_table();
                8:          repeat (n) send_mixed(25, 25, 25);
                default:    repeat (n) send_mixed(30, 30, 37);
            endcase
        end
        s_tvalid = 1'b0;
        calm     = 1'b0;

        wait_quiet();
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
